// ----- src/rhsl_pkg.sv -----
// Shared types, constants and widths for the RGB to HSL conversion pipeline.
// Used by every stage module and by the top level; depends on nothing.
package rhsl_pkg;

  // Fixed field widths
  localparam int CH_W   = 8;
  localparam int HUE_W  = 15;
  localparam int SAT_W  = 13;
  localparam int LSUM_W = 9;
  localparam int CH_MAX = 255;

  // Fixed point scaling
  localparam int HUE_FRAC_BITS = 6;
  localparam int SAT_FRAC_BITS = 12;

  localparam int HUE_SCALE = 1 << HUE_FRAC_BITS;
  localparam int HUE_MUL   = 60 * HUE_SCALE;
  localparam int HUE_120   = 120 * HUE_SCALE;
  localparam int HUE_240   = 240 * HUE_SCALE;
  localparam int HUE_FULL  = 360 * HUE_SCALE;
  localparam int SAT_ONE   = 1 << SAT_FRAC_BITS;

  // Dividend widths: largest hue and saturation numerators
  localparam int HUE_NUM_MAX = CH_MAX * HUE_MUL;
  localparam int SAT_NUM_MAX = CH_MAX * SAT_ONE;
  localparam int NUM_MAX     = (HUE_NUM_MAX > SAT_NUM_MAX) ? HUE_NUM_MAX : SAT_NUM_MAX;
  localparam int NUM_W       = $clog2(NUM_MAX + 1);

  // Reciprocal scaling: ceil(2^K / d) is exact for N < 2^NUM_W and d < 2^CH_W
  localparam int RECIP_K = NUM_W + CH_W;
  localparam int RECIP_W = RECIP_K + 1;
  localparam int PROD_W  = NUM_W + RECIP_W;

  // Quotient widths
  localparam int HQ_W = $clog2(HUE_MUL + 1);
  localparam int SQ_W = $clog2(SAT_ONE + 1);

  // Widths for final hue and saturation arithmetic
  localparam int HUE_CALC_W = $clog2(HUE_FULL + 1);
  localparam int HUE_EXT_W  = (HUE_CALC_W > HUE_W) ? HUE_CALC_W : HUE_W;
  localparam int SAT_EXT_W  = (SQ_W > SAT_W) ? SQ_W : SAT_W;

  // Stream word widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    sector_e           sector;
    logic              neg;
    logic [CH_W-1:0]   mag;
    logic [CH_W-1:0]   delta;
    logic [LSUM_W-1:0] lsum;
  } sort_t;

  typedef struct packed {
    sector_e            sector;
    logic               neg;
    logic               zero;
    logic [LSUM_W-1:0]  lsum;
    logic [NUM_W-1:0]   hue_num;
    logic [RECIP_W-1:0] hue_rcp;
    logic [NUM_W-1:0]   sat_num;
    logic [RECIP_W-1:0] sat_rcp;
  } prep_t;

  typedef struct packed {
    sector_e           sector;
    logic              neg;
    logic              zero;
    logic [LSUM_W-1:0] lsum;
    logic [HQ_W-1:0]   hue_q;
    logic [SQ_W-1:0]   sat_q;
  } quo_t;

endpackage

// ----- src/rgb_to_hsl_converter_top.sv -----
// Top level of the RGB to HSL converter: stream ports, stage chain, output register.
// Depends on rhsl_pkg, rhsl_sort, rhsl_prep and rhsl_mul.
//
// Converts one 8-bit RGB pixel per clock, when the output is not stalled, into hue
// (1/64 degree units), saturation (4096 = 1.0) and lightness as the sum max + min
// (lightness = sum / 510). The block takes a new word in every cycle unless a stall
// reaches back to the input. Each result passes through the four register stages in
// order: channel sorting, dividend setup with a 256-entry reciprocal lookup, the
// reciprocal multiplies, and the sector offset plus output register. Both divisions
// are done exactly by reciprocal multiplication and truncate. Grey pixels give zero
// hue and saturation. A stall holds every full stage; empty stages keep filling.
module rgb_to_hsl_converter_top
  import rhsl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [14:0] hue, [27:15] saturation, [36:28] lightness_sum, [39:37] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  pixel_t pix;
  logic   s1_valid;
  logic   s1_ready;
  sort_t  s1_data;
  logic   s2_valid;
  logic   s2_ready;
  prep_t  s2_data;
  logic   s3_valid;
  logic   s3_ready;
  quo_t   s3_data;

  logic                 out_valid_q;
  logic [HUE_W-1:0]     hue_q;
  logic [HUE_W-1:0]     hue_d;
  logic [SAT_W-1:0]     sat_q;
  logic [SAT_W-1:0]     sat_d;
  logic [LSUM_W-1:0]    lsum_q;
  logic [HUE_EXT_W-1:0] hue_ext;
  logic [HUE_EXT_W-1:0] hq_ext;
  logic [SAT_EXT_W-1:0] sat_ext;
  logic                 out_load;

  // Unpack the input word
  assign pix.red   = s_axis_tdata[CH_W-1:0];
  assign pix.green = s_axis_tdata[2*CH_W-1:CH_W];
  assign pix.blue  = s_axis_tdata[3*CH_W-1:2*CH_W];

  rhsl_sort u_sort (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (pix),
    .out_valid_o(s1_valid),
    .out_ready_i(s1_ready),
    .out_data_o (s1_data)
  );

  rhsl_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s1_valid),
    .in_ready_o (s1_ready),
    .in_data_i  (s1_data),
    .out_valid_o(s2_valid),
    .out_ready_i(s2_ready),
    .out_data_o (s2_data)
  );

  rhsl_mul u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s2_valid),
    .in_ready_o (s2_ready),
    .in_data_i  (s2_data),
    .out_valid_o(s3_valid),
    .out_ready_i(s3_ready),
    .out_data_o (s3_data)
  );

  assign s3_ready = !out_valid_q || m_axis_tready;
  assign out_load = s3_ready && s3_valid;

  // Add the sector offset, wrap negative red hues, clear grey pixels
  always_comb begin
    hq_ext = HUE_EXT_W'(s3_data.hue_q);
    case (s3_data.sector)
      SECT_RED: begin
        if (s3_data.neg && s3_data.hue_q != '0) begin
          hue_ext = HUE_EXT_W'(HUE_FULL) - hq_ext;
        end else if (s3_data.neg) begin
          hue_ext = '0;
        end else begin
          hue_ext = hq_ext;
        end
      end
      SECT_GREEN: begin
        hue_ext = s3_data.neg ? HUE_EXT_W'(HUE_120) - hq_ext
                              : HUE_EXT_W'(HUE_120) + hq_ext;
      end
      SECT_BLUE: begin
        hue_ext = s3_data.neg ? HUE_EXT_W'(HUE_240) - hq_ext
                              : HUE_EXT_W'(HUE_240) + hq_ext;
      end
      default: begin
        hue_ext = '0;
      end
    endcase
    sat_ext = SAT_EXT_W'(s3_data.sat_q);
    if (s3_data.zero) begin
      hue_ext = '0;
      sat_ext = '0;
    end
    hue_d = hue_ext[HUE_W-1:0];
    sat_d = sat_ext[SAT_W-1:0];
  end

  // Output register: hold the word until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s3_ready) begin
      out_valid_q <= s3_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      hue_q  <= hue_d;
      sat_q  <= sat_d;
      lsum_q <= s3_data.lsum;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - HUE_W - SAT_W - LSUM_W)'(0), lsum_q, sat_q, hue_q};

`ifndef SYNTH
  // Input stalls only when every stage is full and the sink holds off
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid && s2_valid && s3_valid && out_valid_q && !m_axis_tready))
    else $error("input stalled with an empty stage");

  // Saturation quotient never exceeds one
  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid |-> (s3_data.sat_q <= SQ_W'(SAT_ONE)))
    else $error("saturation quotient above one");

  // A grey pixel leaves with zero hue and saturation
  a_grey_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && s3_data.zero) |=> (hue_q == '0 && sat_q == '0))
    else $error("grey pixel with nonzero hue or saturation");

  // Hue quotient stays within one sector
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid |-> (s3_data.hue_q <= HQ_W'(HUE_MUL)))
    else $error("hue quotient beyond one sector");
`endif

endmodule

// ----- src/rhsl_sort.sv -----
// Stage 1: find max and min channel, the hue sector and the signed deviation.
// Depends on rhsl_pkg.
module rhsl_sort
  import rhsl_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  pixel_t in_data_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output sort_t  out_data_o
);

  logic            valid_q;
  sort_t           data_q;
  sort_t           data_d;
  logic [CH_W-1:0] mx;
  logic [CH_W-1:0] mn;
  logic [CH_W-1:0] dev_a;
  logic [CH_W-1:0] dev_b;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Pick the sector in red, green, blue order and form its deviation
  always_comb begin
    if (in_data_i.red >= in_data_i.green && in_data_i.red >= in_data_i.blue) begin
      data_d.sector = SECT_RED;
      mx            = in_data_i.red;
      dev_a         = in_data_i.green;
      dev_b         = in_data_i.blue;
    end else if (in_data_i.green >= in_data_i.blue) begin
      data_d.sector = SECT_GREEN;
      mx            = in_data_i.green;
      dev_a         = in_data_i.blue;
      dev_b         = in_data_i.red;
    end else begin
      data_d.sector = SECT_BLUE;
      mx            = in_data_i.blue;
      dev_a         = in_data_i.red;
      dev_b         = in_data_i.green;
    end
    mn = in_data_i.red;
    if (in_data_i.green < mn) mn = in_data_i.green;
    if (in_data_i.blue < mn) mn = in_data_i.blue;
    data_d.neg   = dev_a < dev_b;
    data_d.mag   = data_d.neg ? (dev_b - dev_a) : (dev_a - dev_b);
    data_d.delta = mx - mn;
    data_d.lsum  = LSUM_W'(mx) + LSUM_W'(mn);
  end

  // Hold the word until the next stage takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ----- src/rhsl_prep.sv -----
// Stage 2: build both dividends and look up the reciprocals of both divisors.
// Depends on rhsl_pkg.
module rhsl_prep
  import rhsl_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  sort_t in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output prep_t out_data_o
);

  localparam int TAB_N = 1 << CH_W;

  logic               valid_q;
  prep_t              data_q;
  prep_t              data_d;
  logic [RECIP_W-1:0] rcp_tab [TAB_N];
  logic [LSUM_W-1:0]  den_full;
  logic [CH_W-1:0]    den;

  // Reciprocal table: ceil(2^K / d); entry zero stands in for a divisor of one
  for (genvar i = 0; i < TAB_N; i++) begin : g_rcp
    localparam longint DIV = (i == 0) ? 1 : i;
    localparam longint RCP = ((64'd1 << RECIP_K) + DIV - 1) / DIV;
    assign rcp_tab[i] = RECIP_W'(RCP);
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Saturation divisor 255 - |sum - 255|, always below 256
  always_comb begin
    if (in_data_i.lsum > LSUM_W'(CH_MAX)) begin
      den_full = LSUM_W'(2 * CH_MAX) - in_data_i.lsum;
    end else begin
      den_full = in_data_i.lsum;
    end
    den = den_full[CH_W-1:0];

    data_d.sector  = in_data_i.sector;
    data_d.neg     = in_data_i.neg;
    data_d.zero    = in_data_i.delta == '0;
    data_d.lsum    = in_data_i.lsum;
    data_d.hue_num = NUM_W'(in_data_i.mag) * NUM_W'(HUE_MUL);
    data_d.hue_rcp = rcp_tab[in_data_i.delta];
    data_d.sat_num = NUM_W'(in_data_i.delta) << SAT_FRAC_BITS;
    data_d.sat_rcp = rcp_tab[den];
  end

  // Hold the word until the next stage takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ----- src/rhsl_mul.sv -----
// Stage 3: multiply each dividend by its reciprocal to get the truncated quotients.
// Depends on rhsl_pkg.
module rhsl_mul
  import rhsl_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  prep_t in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output quo_t  out_data_o
);

  logic              valid_q;
  quo_t              data_q;
  quo_t              data_d;
  logic [PROD_W-1:0] hue_prod;
  logic [PROD_W-1:0] sat_prod;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Quotient is the product shifted down by the reciprocal scale
  always_comb begin
    hue_prod = PROD_W'(in_data_i.hue_num) * PROD_W'(in_data_i.hue_rcp);
    sat_prod = PROD_W'(in_data_i.sat_num) * PROD_W'(in_data_i.sat_rcp);

    data_d.sector = in_data_i.sector;
    data_d.neg    = in_data_i.neg;
    data_d.zero   = in_data_i.zero;
    data_d.lsum   = in_data_i.lsum;
    data_d.hue_q  = hue_prod[RECIP_K +: HQ_W];
    data_d.sat_q  = sat_prod[RECIP_K +: SQ_W];
  end

  // Hold the word until the next stage takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule
